@@ hdl/spvc_pkg.sv @@
// ----------------------------------------------------------------------------
// Stroke peak/valley counter package
// Shared sizes, reset values, register indexes and the structs that pass
// between the pipeline stages.
// ----------------------------------------------------------------------------
package spvc_pkg;

  // Block geometry.
  localparam int AVERAGE_TAPS     = 12;
  localparam int WINDOW_LEN       = 15;
  localparam int CONFIRM_SPACINGS = 5;

  // Field widths.
  localparam int ACCEL_W   = 16;
  localparam int SMOOTH_W  = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int TOTAL_W   = 32;
  localparam int ADDED_W   = 3;
  localparam int SPACING_W = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SWING  = 2'd0,
    CFG_MIN_PERIOD = 2'd1,
    CFG_MAX_PERIOD = 2'd2
  } cfg_index_t;

  localparam logic [CFG_W-1:0] MIN_SWING_RST  = 8'd30;
  localparam logic [CFG_W-1:0] MIN_PERIOD_RST = 8'd20;
  localparam logic [CFG_W-1:0] MAX_PERIOD_RST = 8'd100;

  typedef logic signed [SMOOTH_W-1:0] smooth_t;

  localparam smooth_t PEAK_RST   = -8'sd127;
  localparam smooth_t VALLEY_RST = 8'sd127;

  // Moving average: the sum is divided by the tap count through a reciprocal.
  localparam int AVG_SLOT_W = $clog2(AVERAGE_TAPS);
  localparam int AVG_SUM_W  = SMOOTH_W + $clog2(AVERAGE_TAPS);
  localparam int AVG_SHIFT  = 18;
  localparam int AVG_RECIP  = ((1 << AVG_SHIFT) + AVERAGE_TAPS - 1) / AVERAGE_TAPS;

  // Detection window.
  localparam int WIN_FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int WIN_CTR    = WINDOW_LEN / 2;
  localparam int WIN_HALF   = WINDOW_LEN - 1 - WIN_CTR;
  localparam int RISE_W     = $clog2(WIN_CTR + 1);

  // Threshold: divide by five through a reciprocal.
  localparam int DIV5_SHIFT = 12;
  localparam int DIV5_RECIP = ((1 << DIV5_SHIFT) + 4) / 5;

  // Confirmation: reference is the mean of all logged spacings but the first.
  localparam int CC_W        = $clog2(CONFIRM_SPACINGS);
  localparam int LOG_SUM_W   = SPACING_W + $clog2(CONFIRM_SPACINGS);
  localparam int REF_SHIFT   = 16;
  localparam int REF_RECIP_W = REF_SHIFT + 1;
  localparam int REF_RECIP   =
    ((1 << REF_SHIFT) + CONFIRM_SPACINGS - 2) / (CONFIRM_SPACINGS - 1);

  typedef struct packed {
    logic [CFG_W-1:0] min_swing;
    logic [CFG_W-1:0] min_period;
    logic [CFG_W-1:0] max_period;
  } spvc_cfg_t;

  typedef struct packed {
    smooth_t              avg;
    smooth_t              mid;
    logic                 peak_hit;
    logic                 valley_hit;
    logic [SPACING_W-1:0] threshold;
  } detect_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] stroke_total;
    logic [ADDED_W-1:0] strokes_added;
    logic               swim_confirmed;
    smooth_t            smoothed_value;
  } result_t;

endpackage

@@ hdl/spvc_if.sv @@
// ----------------------------------------------------------------------------
// Stroke counter stream interfaces
// Valid/ready channels for the sample input and the result output.
// ----------------------------------------------------------------------------
interface spvc_in_if import spvc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_sample;

  modport source (output valid, output accel_sample, input ready);
  modport sink (input valid, input accel_sample, output ready);
endinterface

interface spvc_out_if import spvc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] stroke_total;
  logic [ADDED_W-1:0] strokes_added;
  logic               swim_confirmed;
  smooth_t            smoothed_value;

  modport source (output valid, output stroke_total, output strokes_added,
                  output swim_confirmed, output smoothed_value, input ready);
  modport sink (input valid, input stroke_total, input strokes_added,
                input swim_confirmed, input smoothed_value, output ready);
endinterface

@@ hdl/stroke_peak_valley_counter.sv @@
// ----------------------------------------------------------------------------
// Stroke peak/valley counter
// Smooths one accelerometer axis, finds peak/valley pairs and counts
// swimming strokes from the spacing of those pairs.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   -------  ---------  -------------------  ----------------------------------
//   sample   in         valid/ready          accel_sample (16b signed)
//   result   out        valid/ready          stroke_total, strokes_added,
//                                            swim_confirmed, smoothed_value
//   cfg      in         cfg_write, no wait   cfg_index, cfg_data (8b)
//
// One transaction per cycle is sustained while result.ready stays high.
// Each pipeline stage (average, window, stroke) has one register; the first
// loads on the edge that takes the sample, then the window and result
// registers. The stages advance independently, so a stalled result only blocks
// the input once every stage holds an item. Reset is synchronous and active
// high; it clears all stages, loads the register defaults and needs no
// clearing pass, so a sample can be taken in the first cycle after reset.
//
module stroke_peak_valley_counter import spvc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  spvc_in_if.sink              sample,
  spvc_out_if.source           result
);

  spvc_cfg_t cfg;

  logic    en_avg;
  logic    en_win;
  logic    en_stroke;
  logic    avg_valid;
  smooth_t avg;
  logic    det_valid;
  detect_t det;
  logic    res_valid;
  result_t res;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_swing  <= MIN_SWING_RST;
      cfg.min_period <= MIN_PERIOD_RST;
      cfg.max_period <= MAX_PERIOD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MIN_SWING:  cfg.min_swing  <= cfg_data;
        CFG_MIN_PERIOD: cfg.min_period <= cfg_data;
        CFG_MAX_PERIOD: cfg.max_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each stage loads when the stage after it is empty or moving on, so
  // bubbles collapse while the result side is stalled.
  assign en_stroke    = !res_valid || result.ready;
  assign en_win       = !det_valid || en_stroke;
  assign en_avg       = !avg_valid || en_win;
  assign sample.ready = en_avg;

  // Stage one: scale and moving average.
  spvc_average u_average (
    .clk          (clk),
    .rst          (rst),
    .en           (en_avg),
    .in_valid     (sample.valid),
    .accel_sample (sample.accel_sample),
    .avg_valid    (avg_valid),
    .avg          (avg)
  );

  // Stage two: detection window, centre tests and swing threshold.
  spvc_window u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (en_win),
    .in_valid  (avg_valid),
    .avg       (avg),
    .cfg       (cfg),
    .det_valid (det_valid),
    .det       (det)
  );

  // Stage three: pairing, confirmation and stroke count into the result register.
  spvc_stroke u_stroke (
    .clk       (clk),
    .rst       (rst),
    .en        (en_stroke),
    .in_valid  (det_valid),
    .det       (det),
    .cfg       (cfg),
    .out_valid (res_valid),
    .result    (res)
  );

  assign result.valid          = res_valid;
  assign result.stroke_total   = res.stroke_total;
  assign result.strokes_added  = res.strokes_added;
  assign result.swim_confirmed = res.swim_confirmed;
  assign result.smoothed_value = res.smoothed_value;

endmodule

@@ hdl/spvc_average.sv @@
// ----------------------------------------------------------------------------
// Moving average stage
// Scales each sample and averages it over the tap ring with a running sum.
// ----------------------------------------------------------------------------
module spvc_average import spvc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [ACCEL_W-1:0] accel_sample,
  output logic                      avg_valid,
  output smooth_t                   avg
);

  smooth_t                              ring [AVERAGE_TAPS];
  logic [AVG_SLOT_W-1:0]                slot;
  logic signed [AVG_SUM_W-1:0]          sum;
  logic signed [AVG_SUM_W-1:0]          sum_next;
  smooth_t                              scaled;
  logic [AVG_SUM_W-1:0]                 mag;
  logic [AVG_SUM_W+AVG_SHIFT-1:0]       prod;
  logic [SMOOTH_W-1:0]                  quot;
  smooth_t                              avg_next;
  logic                                 take;

  assign take = en && in_valid;

  always_comb begin
    scaled   = smooth_t'(accel_sample[ACCEL_W-1 -: SMOOTH_W]);
    sum_next = sum - AVG_SUM_W'(ring[slot]) + AVG_SUM_W'(scaled);
    mag      = sum_next[AVG_SUM_W-1] ? AVG_SUM_W'(-sum_next) : AVG_SUM_W'(sum_next);
    // Truncating division by the tap count, done on the magnitude.
    prod     = (AVG_SUM_W+AVG_SHIFT)'(mag) * (AVG_SUM_W+AVG_SHIFT)'(AVG_RECIP);
    quot     = prod[AVG_SHIFT +: SMOOTH_W];
    avg_next = sum_next[AVG_SUM_W-1] ? smooth_t'(-quot) : smooth_t'(quot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      sum       <= '0;
      avg_valid <= 1'b0;
      for (int i = 0; i < AVERAGE_TAPS; i++) begin
        ring[i] <= '0;
      end
    end else begin
      if (en) begin
        avg_valid <= in_valid;
      end
      if (take) begin
        ring[slot] <= scaled;
        slot       <= (slot == AVG_SLOT_W'(AVERAGE_TAPS - 1)) ? '0 : slot + 1'b1;
        sum        <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      avg <= avg_next;
    end
  end

endmodule

@@ hdl/spvc_window.sv @@
// ----------------------------------------------------------------------------
// Detection window stage
// Loads the window, tests its centre for a peak or valley and refreshes the
// swing threshold.
// ----------------------------------------------------------------------------
module spvc_window import spvc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  smooth_t   avg,
  input  spvc_cfg_t cfg,
  output logic      det_valid,
  output detect_t   det
);

  smooth_t                  win      [WINDOW_LEN];
  smooth_t                  win_next [WINDOW_LEN];
  logic [WIN_FILL_W-1:0]    fill;
  logic                     full;
  logic [WINDOW_LEN-2:0]    rise;
  logic [RISE_W-1:0]        rise_left;
  logic [RISE_W-1:0]        rise_right;
  smooth_t                  mid;
  logic                     peak_hit;
  logic                     valley_hit;
  logic [CFG_W-1:0]         refresh_count;
  smooth_t                  span_high;
  smooth_t                  span_low;
  logic [SPACING_W-1:0]     threshold;
  logic                     refresh_go;
  logic signed [SMOOTH_W:0] span_sdiff;
  logic [SMOOTH_W:0]        span_diff;
  logic [SMOOTH_W+DIV5_SHIFT+1:0] div5_prod;
  logic [SPACING_W-1:0]     div5_quot;
  logic [SPACING_W-1:0]     threshold_next;
  logic                     take;

  assign take = en && in_valid;
  assign full = (fill == WIN_FILL_W'(WINDOW_LEN));

  // Fill by slot until full, then shift toward slot zero.
  always_comb begin
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      if (full) begin
        win_next[i] = win[i+1];
      end else if (fill == WIN_FILL_W'(i)) begin
        win_next[i] = avg;
      end else begin
        win_next[i] = win[i];
      end
    end
    if (full || fill == WIN_FILL_W'(WINDOW_LEN - 1)) begin
      win_next[WINDOW_LEN-1] = avg;
    end else begin
      win_next[WINDOW_LEN-1] = win[WINDOW_LEN-1];
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      rise[i] = (win_next[i] < win_next[i+1]);
    end
    rise_left  = '0;
    rise_right = '0;
    for (int i = 0; i < WIN_CTR; i++) begin
      rise_left = rise_left + RISE_W'(rise[i]);
    end
    for (int i = WIN_CTR; i < WINDOW_LEN - 1; i++) begin
      rise_right = rise_right + RISE_W'(rise[i]);
    end
    mid = win_next[WIN_CTR];
    peak_hit = (mid > win_next[WIN_CTR-1]) && (mid >= win_next[WIN_CTR+1]) &&
               (rise_left >= RISE_W'(WIN_CTR - 3)) &&
               ((RISE_W'(WIN_HALF) - rise_right) >= RISE_W'(WIN_CTR - 2));
    valley_hit = (mid <= win_next[WIN_CTR-1]) && (mid < win_next[WIN_CTR+1]) &&
                 ((RISE_W'(WIN_CTR) - rise_left) >= RISE_W'(WIN_CTR - 2)) &&
                 (rise_right >= RISE_W'(WIN_CTR - 3));
  end

  // New threshold is two fifths of the span seen over the last interval.
  always_comb begin
    refresh_go = (refresh_count < cfg.max_period);
    span_sdiff = (SMOOTH_W+1)'(span_high) - (SMOOTH_W+1)'(span_low);
    span_diff  = span_sdiff[SMOOTH_W] ? (SMOOTH_W+1)'(-span_sdiff)
                                      : (SMOOTH_W+1)'(span_sdiff);
    div5_prod  = (SMOOTH_W+DIV5_SHIFT+2)'({span_diff, 1'b0}) *
                 (SMOOTH_W+DIV5_SHIFT+2)'(DIV5_RECIP);
    div5_quot  = div5_prod[DIV5_SHIFT +: SPACING_W];
    if (refresh_go) begin
      threshold_next = threshold;
    end else if (div5_quot < cfg.min_swing) begin
      threshold_next = cfg.min_swing;
    end else begin
      threshold_next = div5_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      refresh_count <= '0;
      span_high     <= '0;
      span_low      <= '0;
      threshold     <= '0;
      det_valid     <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (en) begin
        det_valid <= in_valid;
      end
      if (take) begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
          win[i] <= win_next[i];
        end
        fill      <= full ? fill : fill + 1'b1;
        threshold <= threshold_next;
        if (refresh_go) begin
          refresh_count <= refresh_count + 1'b1;
          if (span_high < avg) begin
            span_high <= avg;
          end
          if (span_low > avg) begin
            span_low <= avg;
          end
        end else begin
          refresh_count <= '0;
          span_high     <= '0;
          span_low      <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      det.avg        <= avg;
      det.mid        <= mid;
      det.peak_hit   <= peak_hit;
      det.valley_hit <= valley_hit;
      det.threshold  <= threshold_next;
    end
  end

endmodule

@@ hdl/spvc_stroke.sv @@
// ----------------------------------------------------------------------------
// Stroke stage
// Pairs peaks with valleys, logs spacings, confirms swimming and counts
// strokes. Its register is the result register of the block.
// ----------------------------------------------------------------------------
module spvc_stroke import spvc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  detect_t   det,
  input  spvc_cfg_t cfg,
  output logic      out_valid,
  output result_t   result
);

  smooth_t              best_peak;
  smooth_t              best_valley;
  logic                 peak_seen;
  logic                 valley_seen;
  logic [SPACING_W-1:0] since_pair;
  logic [SPACING_W-1:0] spacing_log [CONFIRM_SPACINGS];
  logic [SPACING_W-1:0] reference_spacing;
  logic                 confirmed_flag;
  logic [CC_W-1:0]      confirm_count;
  logic [SPACING_W-1:0] idle_count;
  logic [TOTAL_W-1:0]   stroke_count;

  smooth_t              best_peak_next;
  smooth_t              best_valley_next;
  logic                 peak_seen_next;
  logic                 valley_seen_next;
  logic [SPACING_W-1:0] since_pair_next;
  logic [SPACING_W-1:0] reference_next;
  logic                 confirmed_next;
  logic [CC_W-1:0]      confirm_count_next;
  logic [SPACING_W-1:0] idle_count_next;
  logic [TOTAL_W-1:0]   stroke_count_next;
  logic [ADDED_W-1:0]   added;
  logic                 log_write;

  logic signed [SMOOTH_W:0]         pair_sdiff;
  logic [SMOOTH_W:0]                pair_diff;
  logic                             pair_take;
  logic                             spacing_ok;
  logic [CC_W:0]                    count_inc;
  logic [LOG_SUM_W-1:0]             log_sum;
  logic [LOG_SUM_W+REF_RECIP_W-1:0] ref_prod;
  logic [SPACING_W-1:0]             ref_mean;
  logic [SPACING_W-1:0]             dev;
  logic [SPACING_W+2:0]             dev_x5;
  logic [SPACING_W+2:0]             ref_x2;
  logic [SPACING_W:0]               idle_inc;
  logic                             take;

  assign take = en && in_valid;

  // Datapath pieces that do not depend on the branch taken.
  always_comb begin
    count_inc = (CC_W+1)'(confirm_count) + 1'b1;
    // The entry written now stands in for its old contents.
    log_sum = '0;
    for (int i = 1; i < CONFIRM_SPACINGS; i++) begin
      if (confirm_count == CC_W'(i)) begin
        log_sum = log_sum + LOG_SUM_W'(since_pair);
      end else begin
        log_sum = log_sum + LOG_SUM_W'(spacing_log[i]);
      end
    end
    ref_prod = (LOG_SUM_W+REF_RECIP_W)'(log_sum) * (LOG_SUM_W+REF_RECIP_W)'(REF_RECIP);
    ref_mean = ref_prod[REF_SHIFT +: SPACING_W];
    dev      = (since_pair > reference_spacing) ? since_pair - reference_spacing
                                                : reference_spacing - since_pair;
    dev_x5   = (SPACING_W+3)'({dev, 2'b00}) + (SPACING_W+3)'(dev);
    ref_x2   = (SPACING_W+3)'({reference_spacing, 1'b0});
  end

  always_comb begin
    best_peak_next     = best_peak;
    best_valley_next   = best_valley;
    peak_seen_next     = peak_seen;
    valley_seen_next   = valley_seen;
    reference_next     = reference_spacing;
    confirmed_next     = confirmed_flag;
    confirm_count_next = confirm_count;
    idle_count_next    = idle_count;
    stroke_count_next  = stroke_count;
    added              = '0;
    log_write          = 1'b0;

    if (det.peak_hit && det.mid > best_peak) begin
      best_peak_next = det.mid;
      peak_seen_next = 1'b1;
    end
    if (det.valley_hit && det.mid < best_valley) begin
      best_valley_next = det.mid;
      valley_seen_next = 1'b1;
    end

    pair_sdiff = (SMOOTH_W+1)'(best_peak_next) - (SMOOTH_W+1)'(best_valley_next);
    pair_diff  = pair_sdiff[SMOOTH_W] ? (SMOOTH_W+1)'(-pair_sdiff)
                                      : (SMOOTH_W+1)'(pair_sdiff);
    pair_take  = peak_seen_next && valley_seen_next &&
                 (pair_diff > (SMOOTH_W+1)'(det.threshold));
    spacing_ok = pair_take && (since_pair > cfg.min_period) &&
                 (since_pair < cfg.max_period);

    if (spacing_ok) begin
      if (!confirmed_flag) begin
        log_write = 1'b1;
        if (count_inc == (CC_W+1)'(CONFIRM_SPACINGS)) begin
          reference_next     = ref_mean;
          confirmed_next     = 1'b1;
          stroke_count_next  = stroke_count + TOTAL_W'(CONFIRM_SPACINGS);
          added              = ADDED_W'(CONFIRM_SPACINGS);
          confirm_count_next = '0;
        end else begin
          confirm_count_next = count_inc[CC_W-1:0];
        end
      end else if (dev_x5 < ref_x2) begin
        stroke_count_next = stroke_count + 1'b1;
        added             = ADDED_W'(1);
      end else begin
        confirmed_next     = 1'b0;
        confirm_count_next = '0;
      end
      idle_count_next = '0;
    end

    since_pair_next = since_pair;
    if (pair_take) begin
      since_pair_next  = '0;
      peak_seen_next   = 1'b0;
      valley_seen_next = 1'b0;
      best_peak_next   = PEAK_RST;
      best_valley_next = VALLEY_RST;
    end
    if (since_pair_next != '1) begin
      since_pair_next = since_pair_next + 1'b1;
    end

    // Idle timeout drops confirmation when no spacing has counted for a while.
    idle_inc = (SPACING_W+1)'(idle_count_next) + 1'b1;
    if (idle_inc > (SPACING_W+1)'(cfg.max_period)) begin
      idle_count_next    = '0;
      confirmed_next     = 1'b0;
      confirm_count_next = '0;
    end else begin
      idle_count_next = idle_inc[SPACING_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_peak         <= PEAK_RST;
      best_valley       <= VALLEY_RST;
      peak_seen         <= 1'b0;
      valley_seen       <= 1'b0;
      since_pair        <= '0;
      reference_spacing <= '0;
      confirmed_flag    <= 1'b0;
      confirm_count     <= '0;
      idle_count        <= '0;
      stroke_count      <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (en) begin
        out_valid <= in_valid;
      end
      if (take) begin
        best_peak         <= best_peak_next;
        best_valley       <= best_valley_next;
        peak_seen         <= peak_seen_next;
        valley_seen       <= valley_seen_next;
        since_pair        <= since_pair_next;
        reference_spacing <= reference_next;
        confirmed_flag    <= confirmed_next;
        confirm_count     <= confirm_count_next;
        idle_count        <= idle_count_next;
        stroke_count      <= stroke_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && log_write) begin
      spacing_log[confirm_count] <= since_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.stroke_total   <= stroke_count_next;
      result.strokes_added  <= added;
      result.swim_confirmed <= confirmed_next;
      result.smoothed_value <= det.avg;
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Stroke peak/valley counter testbench
// Drives accelerometer samples through the valid/ready input channel, keeps
// its own sample-by-sample model of the smoothing, detection and stroke logic, and
// compares every result transaction with the model field by field. The run
// covers register extremes, several handshake idling patterns, swim-like
// waveforms, noise and flat stretches.
// ----------------------------------------------------------------------------
module testbench;
  import spvc_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung.
  // Gaps and stalls are random at 70 percent at worst, so a correct block
  // never comes close to this.
  localparam int WATCHDOG_LIMIT = 2000;
  // The result path is three stages deep; the settle time covers it.
  localparam int SETTLE_CYCLES  = 8;
  localparam int CENTER         = WINDOW_LEN / 2;
  localparam int SIDE_STEPS     = WINDOW_LEN - 1 - CENTER;

  logic             clk;
  logic             rst;
  logic             cfg_write;
  cfg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  spvc_in_if  sample_if ();
  spvc_out_if result_if ();

  stroke_peak_valley_counter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_if),
    .result    (result_if)
  );

  // Results the model has produced for accepted samples, oldest first.
  result_t pending_results[$];
  int      error_count;
  int      stall_cycles;
  // Percent chance per cycle that the sample side idles / the result side
  // holds ready low.
  int      idle_pct;
  int      stall_pct;

  // --------------------------------------------------------------------------
  // Model state. All values are kept as plain integers in their legal ranges;
  // they are truncated to the port widths only when a result is formed.
  // --------------------------------------------------------------------------
  int          cfg_min_swing;
  int          cfg_min_period;
  int          cfg_max_period;
  int          avg_taps[AVERAGE_TAPS];
  int          avg_ptr;
  int          win_vals[WINDOW_LEN];
  int          win_count;
  int          refresh_ctr;
  int          span_max;
  int          span_min;
  int          swing_thr;
  int          peak_best;
  int          valley_best;
  bit          peak_flag;
  bit          valley_flag;
  int          pair_gap;
  int          gap_log[CONFIRM_SPACINGS];
  int          gap_ref;
  bit          swim_flag;
  int          gap_count;
  int          quiet_ctr;
  logic [31:0] stroke_ctr;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int abs_diff(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Number of positions i in [from_slot, to_slot) where the window rises.
  function automatic int count_window_rises(input int from_slot, input int to_slot);
    int n = 0;
    for (int i = from_slot; i < to_slot; i++) begin
      if (win_vals[i] < win_vals[i + 1]) n++;
    end
    return n;
  endfunction

  task automatic clear_stroke_model();
    cfg_min_swing  = int'(MIN_SWING_RST);
    cfg_min_period = int'(MIN_PERIOD_RST);
    cfg_max_period = int'(MAX_PERIOD_RST);
    foreach (avg_taps[i]) avg_taps[i] = 0;
    foreach (win_vals[i]) win_vals[i] = 0;
    foreach (gap_log[i]) gap_log[i] = 0;
    avg_ptr     = 0;
    win_count   = 0;
    refresh_ctr = 0;
    span_max    = 0;
    span_min    = 0;
    swing_thr   = 0;
    peak_best   = -127;
    valley_best = 127;
    peak_flag   = 1'b0;
    valley_flag = 1'b0;
    pair_gap    = 0;
    gap_ref     = 0;
    swim_flag   = 1'b0;
    gap_count   = 0;
    quiet_ctr   = 0;
    stroke_ctr  = '0;
  endtask

  // Advances the model by one accepted sample and returns the result that
  // the block must produce for it.
  function automatic result_t next_stroke_result(input logic signed [ACCEL_W-1:0] raw);
    result_t            r;
    int                 sum;
    int                 avg;
    int                 mid;
    int                 acc;
    logic [ADDED_W-1:0] added;
    sum   = 0;
    added = '0;

    // Scale by the upper byte, then a moving average that truncates toward
    // zero (integer division in SystemVerilog already does).
    avg_taps[avg_ptr] = int'($signed(raw[15:8]));
    avg_ptr = (avg_ptr == AVERAGE_TAPS - 1) ? 0 : avg_ptr + 1;
    foreach (avg_taps[i]) sum += avg_taps[i];
    avg = sum / AVERAGE_TAPS;

    // The window fills slot by slot after reset, then shifts.
    if (win_count >= WINDOW_LEN) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) win_vals[i] = win_vals[i + 1];
      win_count = WINDOW_LEN - 1;
    end
    win_vals[win_count] = avg;
    win_count++;

    // Swing threshold refresh: 40 percent of the span seen, never below the
    // configured floor.
    if (refresh_ctr < cfg_max_period) begin
      refresh_ctr++;
      if (span_max < avg) span_max = avg;
      if (span_min > avg) span_min = avg;
    end else begin
      swing_thr = (2 * abs_diff(span_max, span_min)) / 5;
      if (swing_thr < cfg_min_swing) swing_thr = cfg_min_swing;
      span_max    = 0;
      span_min    = 0;
      refresh_ctr = 0;
    end

    mid = win_vals[CENTER];

    if (mid > win_vals[CENTER - 1] && mid >= win_vals[CENTER + 1] &&
        count_window_rises(0, CENTER) >= CENTER - 3 &&
        SIDE_STEPS - count_window_rises(CENTER, WINDOW_LEN - 1) >= CENTER - 2 &&
        mid > peak_best) begin
      peak_best = mid;
      peak_flag = 1'b1;
    end

    if (mid <= win_vals[CENTER - 1] && mid < win_vals[CENTER + 1] &&
        CENTER - count_window_rises(0, CENTER) >= CENTER - 2 &&
        count_window_rises(CENTER, WINDOW_LEN - 1) >= CENTER - 3 &&
        mid < valley_best) begin
      valley_best = mid;
      valley_flag = 1'b1;
    end

    if (peak_flag && valley_flag && abs_diff(peak_best, valley_best) > swing_thr) begin
      if (pair_gap > cfg_min_period && pair_gap < cfg_max_period) begin
        if (!swim_flag) begin
          if (gap_count >= CONFIRM_SPACINGS) gap_count = 0;
          gap_log[gap_count] = pair_gap;
          gap_count++;
          if (gap_count == CONFIRM_SPACINGS) begin
            // Reference spacing leaves out the first logged spacing.
            acc = 0;
            for (int i = 1; i < CONFIRM_SPACINGS; i++) acc += gap_log[i];
            gap_ref    = acc / (CONFIRM_SPACINGS - 1);
            swim_flag  = 1'b1;
            stroke_ctr = stroke_ctr + CONFIRM_SPACINGS;
            added      = ADDED_W'(CONFIRM_SPACINGS);
            gap_count  = 0;
          end
        end else if (5 * abs_diff(pair_gap, gap_ref) < 2 * gap_ref) begin
          stroke_ctr = stroke_ctr + 1;
          added      = ADDED_W'(1);
        end else begin
          swim_flag = 1'b0;
          gap_count = 0;
        end
        quiet_ctr = 0;
      end
      pair_gap    = 0;
      peak_flag   = 1'b0;
      valley_flag = 1'b0;
      peak_best   = -127;
      valley_best = 127;
    end
    if (pair_gap < 255) pair_gap++;

    if (quiet_ctr + 1 > cfg_max_period) begin
      quiet_ctr = 0;
      swim_flag = 1'b0;
      gap_count = 0;
    end else begin
      quiet_ctr++;
    end

    r.stroke_total   = stroke_ctr;
    r.strokes_added  = added;
    r.swim_confirmed = swim_flag;
    r.smoothed_value = smooth_t'(avg);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake drivers. Inputs change on the falling edge; transactions are
  // recognized on the rising edge.
  // --------------------------------------------------------------------------

  // Sends one sample, with a random idle gap first, and records the expected
  // result once the block has taken it. Valid is left high so back-to-back
  // transactions follow without a gap.
  task automatic send_sample(input logic signed [ACCEL_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      sample_if.valid <= 1'b0;
      @(negedge clk);
    end
    sample_if.valid        <= 1'b1;
    sample_if.accel_sample <= value;
    do @(posedge clk); while (!sample_if.ready);
    pending_results.push_back(next_stroke_result(value));
  endtask

  // Result-side back-pressure.
  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no sample pending: stroke_total %0d",
               result_if.stroke_total);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_if.stroke_total !== want.stroke_total) begin
          $error("stroke_total: expected %0d, actual %0d",
                 want.stroke_total, result_if.stroke_total);
          error_count++;
        end
        if (result_if.strokes_added !== want.strokes_added) begin
          $error("strokes_added: expected %0d, actual %0d",
                 want.strokes_added, result_if.strokes_added);
          error_count++;
        end
        if (result_if.swim_confirmed !== want.swim_confirmed) begin
          $error("swim_confirmed: expected %0d, actual %0d",
                 want.swim_confirmed, result_if.swim_confirmed);
          error_count++;
        end
        if (result_if.smoothed_value !== want.smoothed_value) begin
          $error("smoothed_value: expected %0d, actual %0d",
                 want.smoothed_value, result_if.smoothed_value);
          error_count++;
        end
      end
    end
  end

  // Hang detection: any cycle that moves a transaction on either channel
  // restarts the count.
  always @(posedge clk) begin
    if (rst || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Lowers valid and waits until every expected result has come out, then
  // waits out the settle time so the pipeline is surely empty.
  task automatic drain_results();
    @(negedge clk);
    sample_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the model takes the value on the same edge.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_MIN_SWING:  cfg_min_swing  = int'(data);
      CFG_MIN_PERIOD: cfg_min_period = int'(data);
      CFG_MAX_PERIOD: cfg_max_period = int'(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Registers are only touched once the block has gone quiet.
  task automatic apply_settings(input int swing, input int min_p, input int max_p);
    drain_results();
    write_reg(CFG_MIN_SWING, CFG_W'(swing));
    write_reg(CFG_MIN_PERIOD, CFG_W'(min_p));
    write_reg(CFG_MAX_PERIOD, CFG_W'(max_p));
  endtask

  // Phase 0: no idling, 1: sender idles, 2: receiver stalls, 3: both.
  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 70; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 70; end
      default: begin idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Waveform sources
  // --------------------------------------------------------------------------

  // Stroke period in samples, mostly inside the counted band, sometimes
  // anywhere so rejected spacings also occur.
  function automatic int pick_period();
    int lo;
    int hi;
    lo = (cfg_min_period + 2 > 12) ? cfg_min_period + 2 : 12;
    hi = (cfg_max_period - 2 < 40) ? cfg_max_period - 2 : 40;
    if ($urandom_range(99) < 15 || lo > hi) return $urandom_range(6, 120);
    return $urandom_range(lo, hi);
  endfunction

  // Swim-like triangle wave on the scaled axis with small jitter. The period
  // drifts a little from stroke to stroke and now and then jumps, which
  // breaks an established confirmation.
  task automatic send_stroke_wave(input int count);
    int period;
    int amp;
    int ph;
    int half;
    int ramp_pos;
    int level;
    period = pick_period();
    amp    = ($urandom_range(99) < 15) ? $urandom_range(3, 30) : $urandom_range(30, 120);
    ph     = $urandom_range(0, period - 1);
    for (int n = 0; n < count; n++) begin
      half     = period / 2;
      ramp_pos = (ph < half) ? ph : period - ph;
      level    = -amp + (2 * amp * ramp_pos) / half;
      level   += int'($urandom_range(0, 2)) - 1;
      if (level > 127) level = 127;
      if (level < -128) level = -128;
      send_sample({level[7:0], 8'($urandom)});
      ph++;
      if (ph >= period) begin
        ph = 0;
        if ($urandom_range(99) < 5) begin
          period = pick_period();
        end else if ($urandom_range(99) < 10) begin
          period += int'($urandom_range(0, 4)) - 2;
          if (period < 6) period = 6;
        end
      end
    end
  endtask

  // Full-range random samples.
  task automatic send_noise(input int count);
    for (int n = 0; n < count; n++) send_sample(ACCEL_W'($urandom));
  endtask

  // Constant scaled level with random low byte: no peaks, no valleys. The
  // rail values drive the moving average to its extremes.
  task automatic send_flat(input int count);
    int pick;
    logic [7:0] level;
    pick  = $urandom_range(3);
    level = (pick == 0) ? 8'h80 : (pick == 1) ? 8'h7F : 8'($urandom);
    for (int n = 0; n < count; n++) send_sample({level, 8'($urandom)});
  endtask

  // Mostly long stroke segments, with short noise bursts and flat stretches
  // in between.
  task automatic send_swim_mix(input int count);
    int left;
    int seg;
    int kind;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(99);
      if (kind < 75) seg = $urandom_range(120, 300);
      else if (kind < 90) seg = $urandom_range(4, 20);
      else seg = $urandom_range(10, 40);
      if (seg > left) seg = left;
      if (kind < 75) send_stroke_wave(seg);
      else if (kind < 90) send_noise(seg);
      else send_flat(seg);
      left -= seg;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes and sign/byte boundaries of the scaling shift, straight
  // after reset so the window fill and the change to shifting are covered.
  task automatic test_sample_extremes();
    logic signed [ACCEL_W-1:0] edge_values[$];
    edge_values = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh00FF, 16'sh0100,
                    16'shFF00, 16'shFEFF, 16'sh5555, 16'shAAAA, 16'sh7F00, 16'sh80FF,
                    16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0180, 16'shFE7F,
                    16'sh4000, 16'shC000};
    set_idling(0);
    foreach (edge_values[i]) send_sample(edge_values[i]);
  endtask

  // Clean strokes at the reset settings: confirmation, single strokes and
  // the loss of confirmation on a period jump.
  task automatic test_swim_confirmation();
    set_idling(0);
    send_stroke_wave(260);
  endtask

  // The same kind of traffic under each idling pattern.
  task automatic test_idle_patterns();
    for (int p = 0; p < 4; p++) begin
      set_idling(p);
      send_swim_mix(110);
    end
  endtask

  // Register extremes: everything counts, nothing can count (shortest
  // refresh and timeout), a tight band, then a random setting.
  task automatic test_register_extremes();
    int swing_set[4];
    int min_set[4];
    int max_set[4];
    swing_set = '{0, 255, 15, $urandom_range(0, 255)};
    min_set   = '{0, 255, 10, $urandom_range(0, 60)};
    max_set   = '{255, 1, 40, $urandom_range(1, 255)};
    for (int s = 0; s < 4; s++) begin
      apply_settings(swing_set[s], min_set[s], max_set[s]);
      set_idling(s + 1);
      send_swim_mix(50);
    end
  endtask

  // Back at the reset settings: a long flat stretch lets the pair spacing
  // saturate and the idle timeout drop confirmation, then strokes resume.
  task automatic test_quiet_stretch();
    apply_settings(int'(MIN_SWING_RST), int'(MIN_PERIOD_RST), int'(MAX_PERIOD_RST));
    set_idling(3);
    send_flat(270);
    send_stroke_wave(60);
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_index              = CFG_MIN_SWING;
    cfg_data               = '0;
    sample_if.valid        = 1'b0;
    sample_if.accel_sample = '0;
    result_if.ready        = 1'b0;
    error_count            = 0;
    stall_cycles           = 0;
    idle_pct               = 0;
    stall_pct              = 0;
    clear_stroke_model();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_sample_extremes();
    test_swim_confirmation();
    test_idle_patterns();
    test_register_extremes();
    test_quiet_stretch();

    // Let every outstanding result come out; the watchdog covers a hang.
    drain_results();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
